[rtl/gent_pkg.sv]
// ----------------------------------------------------------------------------
// gent_pkg: shared types and constants
// Register indexes, reset values, fixed field widths and the configuration
// bundle used by the gradient extremum edge thinning block.
// ----------------------------------------------------------------------------
package gent_pkg;

  localparam int unsigned MaxWidthDefault = 1024;
  localparam int unsigned GradBitsDefault = 16;

  localparam int unsigned RowW      = 12;
  localparam int unsigned ThrW      = 15;
  localparam int unsigned ImgWidthW = 11;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [ThrW-1:0]      ThresholdReset = ThrW'(0);
  localparam logic [ImgWidthW-1:0] WidthReset     = ImgWidthW'(640);
  localparam logic [RowW-1:0]      HeightReset    = RowW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0]      threshold;
    logic [ImgWidthW-1:0] width;
    logic [RowW-1:0]      height;
  } cfg_t;

endpackage

[rtl/gent_front.sv]
// ----------------------------------------------------------------------------
// gent_front: position tracking, line store and window classification
// One pixel per cycle while the queue has room; reads two rows above from
// the line store, forms the 3x3 window and pushes results for interior centers.
// ----------------------------------------------------------------------------
module gent_front
  import gent_pkg::*;
#(
  parameter int unsigned MaxWidth = MaxWidthDefault,
  parameter int unsigned GradBits = GradBitsDefault,
  parameter int unsigned ColW     = $clog2(MaxWidth)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [GradBits-1:0] in_grad_x_i,
  input  logic signed [GradBits-1:0] in_grad_y_i,
  input  logic                       in_frame_start_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output logic [ColW+RowW:0]         q_data_o
);

  localparam int unsigned CmpW  = (ColW + 1 > ImgWidthW) ? ColW + 1 : ImgWidthW;
  localparam int unsigned ExtW  = ((GradBits > ThrW) ? GradBits : ThrW) + 2;
  localparam int unsigned LineW = 4 * GradBits;

  typedef logic signed [GradBits-1:0] grad_t;

  // strict extremum over the primary pair, confirmed by a diagonal or the
  // alternative pair in the same direction
  function automatic logic extremum(input grad_t c, input grad_t pa, input grad_t pb,
                                    input grad_t qa, input grad_t qb,
                                    input grad_t d0, input grad_t d8,
                                    input grad_t d6, input grad_t d2,
                                    input logic [ThrW-1:0] thr);
    logic signed [ExtW-1:0] cx;
    logic signed [ExtW-1:0] tp;
    logic signed [ExtW-1:0] tn;
    logic                   res;
    cx = ExtW'(c);
    tp = $signed(ExtW'(thr));
    tn = -tp;
    if (cx <= tp && cx >= tn) begin
      res = 1'b0;
    end else if (c > pa && c > pb) begin
      res = (c > d0 && c > d8) || (c > d6 && c > d2) || (c > qa && c > qb);
    end else if (c < pa && c < pb) begin
      res = (c < d0 && c < d8) || (c < d6 && c < d2) || (c < qa && c < qb);
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

  // effective frame size
  logic [CmpW-1:0] width_ext;
  logic [CmpW-1:0] eff_w;
  logic [RowW-1:0] eff_h;

  assign width_ext = CmpW'(cfg_i.width);

  always_comb begin
    if (width_ext > CmpW'(MaxWidth)) begin
      eff_w = CmpW'(MaxWidth);
    end else if (width_ext == '0) begin
      eff_w = CmpW'(1);
    end else begin
      eff_w = width_ext;
    end
  end

  assign eff_h = (cfg_i.height == '0) ? RowW'(1) : cfg_i.height;

  // stage 0: position of the incoming pixel and line store read
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] c0, cur_c;
  logic [RowW-1:0] r0, cur_r;
  logic [RowW:0]   r1, r2;
  logic [ColW:0]   c_inc;
  logic            in_fire;
  logic            s1_fire;
  logic            cur_emit;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    c0 = in_frame_start_i ? '0 : col_q;
    r0 = in_frame_start_i ? '0 : row_q;
    // counter past the row end wraps to the next row
    if (CmpW'(c0) >= eff_w) begin
      cur_c = '0;
      r1    = {1'b0, r0} + (RowW+1)'(1);
    end else begin
      cur_c = c0;
      r1    = {1'b0, r0};
    end
    cur_r = (r1 >= {1'b0, eff_h}) ? '0 : r1[RowW-1:0];

    c_inc = {1'b0, cur_c} + (ColW+1)'(1);
    r2    = {1'b0, cur_r} + (RowW+1)'(1);
    if (CmpW'(c_inc) >= eff_w) begin
      col_d = '0;
      row_d = (r2 >= {1'b0, eff_h}) ? '0 : r2[RowW-1:0];
    end else begin
      col_d = c_inc[ColW-1:0];
      row_d = cur_r;
    end
  end

  assign cur_emit = (cur_c >= ColW'(2)) && (cur_r >= RowW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 registers
  logic            s1_valid_q, s1_valid_d;
  logic            s1_emit_q;
  logic [ColW-1:0] s1_addr_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  grad_t           s1_gx_q, s1_gy_q;

  logic [LineW-1:0] line_mem [0:MaxWidth-1];
  logic [LineW-1:0] rd_q;
  logic [LineW-1:0] fwd_data_q;
  logic             fwd_q;
  logic [LineW-1:0] line;
  logic [LineW-1:0] wr_data;

  assign s1_fire    = s1_valid_q && (!s1_emit_q || !q_full_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_fire) begin
        // same column written back this edge: take the new entry
        fwd_q <= s1_fire && (s1_addr_q == cur_c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_emit_q  <= cur_emit;
      s1_addr_q  <= cur_c;
      s1_col_q   <= cur_c - ColW'(1);
      s1_row_q   <= cur_r - RowW'(1);
      s1_gx_q    <= in_grad_x_i;
      s1_gy_q    <= in_grad_y_i;
      fwd_data_q <= wr_data;
    end
  end

  // line store entry: {x row above, x two above, y row above, y two above}
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= line_mem[cur_c];
    end
    if (s1_fire) begin
      line_mem[s1_addr_q] <= wr_data;
    end
  end

  grad_t xa, xb, ya, yb;

  assign line    = fwd_q ? fwd_data_q : rd_q;
  assign xa      = line[4*GradBits-1:3*GradBits];
  assign xb      = line[3*GradBits-1:2*GradBits];
  assign ya      = line[2*GradBits-1:GradBits];
  assign yb      = line[GradBits-1:0];
  assign wr_data = {s1_gx_q, xa, s1_gy_q, ya};

  // window: column c-2 and c-1, rows top to bottom
  grad_t wx0_q [3];
  grad_t wx1_q [3];
  grad_t wy0_q [3];
  grad_t wy1_q [3];
  grad_t xcol  [3];
  grad_t ycol  [3];

  always_comb begin
    xcol[0] = xb;
    xcol[1] = xa;
    xcol[2] = s1_gx_q;
    ycol[0] = yb;
    ycol[1] = ya;
    ycol[2] = s1_gy_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      for (int k = 0; k < 3; k++) begin
        wx0_q[k] <= wx1_q[k];
        wx1_q[k] <= xcol[k];
        wy0_q[k] <= wy1_q[k];
        wy1_q[k] <= ycol[k];
      end
    end
  end

  logic edge_y, edge_x, edge_flag;

  // y: vertical pair primary, horizontal pair alternative
  assign edge_y = extremum(wy1_q[1], wy1_q[0], wy1_q[2], wy0_q[1], ycol[1],
                           wy0_q[0], ycol[2], wy0_q[2], ycol[0], cfg_i.threshold);
  // x: horizontal pair primary, vertical pair alternative
  assign edge_x = extremum(wx1_q[1], wx0_q[1], xcol[1], wx1_q[0], wx1_q[2],
                           wx0_q[0], xcol[2], wx0_q[2], xcol[0], cfg_i.threshold);
  assign edge_flag = edge_y || edge_x;

  assign q_push_o = s1_fire && s1_emit_q;
  assign q_data_o = {edge_flag, s1_row_q, s1_col_q};

endmodule

[rtl/gent_queue.sv]
// ----------------------------------------------------------------------------
// gent_queue: result queue
// Short first-in first-out buffer between the classifying front and the
// output stage.
// ----------------------------------------------------------------------------
module gent_queue
  import gent_pkg::*;
#(
  parameter int unsigned DataW = RowW + 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [DataW-1:0] data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  logic [DataW-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/gent_back.sv]
// ----------------------------------------------------------------------------
// gent_back: output stage
// Drains the result queue into a registered output that holds each result
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module gent_back
  import gent_pkg::*;
#(
  parameter int unsigned DataW = RowW + 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  logic [DataW-1:0] q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q;

  // load whenever the register is free or being emptied this cycle
  assign q_pop_o = !q_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= q_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/gradient_extremum_edge_thinning.sv]
// ----------------------------------------------------------------------------
// gradient_extremum_edge_thinning: 3x3 gradient non-maximum suppression
// Flags interior pixels that are thresholded strict extrema of the x or y
// gradient and reports every interior pixel with its column and row.
//
//   channel   direction  payload
//   s_axis    in         tdata {grad_y, grad_x}, tuser frame_start
//   m_axis    out        tdata {pixel_row, pixel_column}, tuser edge_flag
//   cfg       in         cfg_index_i register, cfg_data_i value
//
// one pixel per clock sustained while the queue has room; each result
// passes the line store read stage, the queue and the output register.
// the line store holds one 64-bit entry per column (default GradBits),
// read and written once per pixel, bypassed when a column is rewritten at once.
// reset clears counters, handshake and config registers; no clearing pass.
// a four-entry queue absorbs output stalls; when it fills, s_axis_tready drops.
// ----------------------------------------------------------------------------
module gradient_extremum_edge_thinning
  import gent_pkg::*;
#(
  parameter int unsigned MaxWidth = MaxWidthDefault,
  parameter int unsigned GradBits = GradBitsDefault,
  parameter int unsigned ColW     = $clog2(MaxWidth),
  parameter int unsigned InDataW  = ((2 * GradBits + 7) / 8) * 8,
  parameter int unsigned OutDataW = ((ColW + RowW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // bits: grad_x, grad_y
  input  logic [InDataW-1:0]  s_axis_tdata,
  // bits: frame_start
  input  logic                s_axis_tuser,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // bits: pixel_column, pixel_row
  output logic [OutDataW-1:0] m_axis_tdata,
  // bits: edge_flag
  output logic                m_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ResW = ColW + RowW + 1;

  // configuration registers
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= ThresholdReset;
      cfg_q.width     <= WidthReset;
      cfg_q.height    <= HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_THRESHOLD: cfg_q.threshold <= cfg_data_i[ThrW-1:0];
        CFG_WIDTH:     cfg_q.width     <= cfg_data_i[ImgWidthW-1:0];
        CFG_HEIGHT:    cfg_q.height    <= cfg_data_i[RowW-1:0];
        default: begin
        end
      endcase
    end
  end

  logic            q_push, q_full, q_pop, q_empty;
  logic [ResW-1:0] front_data, queue_data, out_data;

  gent_front #(
    .MaxWidth (MaxWidth),
    .GradBits (GradBits),
    .ColW     (ColW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_grad_x_i      (s_axis_tdata[GradBits-1:0]),
    .in_grad_y_i      (s_axis_tdata[2*GradBits-1:GradBits]),
    .in_frame_start_i (s_axis_tuser),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_data_o         (front_data)
  );

  gent_queue #(
    .DataW (ResW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (queue_data)
  );

  gent_back #(
    .DataW (ResW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (queue_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  logic [ColW-1:0] out_col;
  logic [RowW-1:0] out_row;

  assign out_col      = out_data[ColW-1:0];
  assign out_row      = out_data[ColW+RowW-1:ColW];
  assign m_axis_tdata = OutDataW'({out_row, out_col});
  assign m_axis_tuser = out_data[ColW+RowW];

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("result pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("result popped from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_col != '0 && out_row != '0))
    else $error("border pixel reported");

endmodule
